FILE: rtl/wlab_pkg.sv
// ----------------------------------------------------------------------------
// wlab_pkg
// Shared types and constants of the water level alarm buzzer.
// ----------------------------------------------------------------------------
package wlab_pkg;

    localparam int LevelW   = 7;
    localparam int DelayW   = 12;
    localparam int TimeoutW = 20;
    localparam int ClearW   = 21;
    localparam int BeepW    = 12;
    localparam int EventW   = 2;
    localparam int CfgAddrW = 2;
    localparam int CfgDataW = 20;
    localparam int InDataW  = 8;
    localparam int OutDataW = 8;

    localparam logic [LevelW-1:0]   LEVEL_EMPTY  = 7'd0;
    localparam logic [LevelW-1:0]   LEVEL_FULL   = 7'd100;

    localparam logic [BeepW-1:0]    LACK_ON1_END = 12'd500;
    localparam logic [BeepW-1:0]    LACK_OFF_END = 12'd1000;
    localparam logic [BeepW-1:0]    LACK_WIN_END = 12'd1500;

    localparam logic [EventW-1:0]   LACK_EVENTS_MAX = 2'd2;

    localparam logic [DelayW-1:0]   LACK_DELAY_RST      = 12'd3000;
    localparam logic [DelayW-1:0]   FULL_DELAY_RST      = 12'd3000;
    localparam logic [TimeoutW-1:0] CLEAR_TIMEOUT_RST   = 20'd180000;
    localparam logic [DelayW-1:0]   LONG_BEEP_TICKS_RST = 12'd3000;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_LACK_DELAY      = 2'd0,
        CFG_FULL_DELAY      = 2'd1,
        CFG_CLEAR_TIMEOUT   = 2'd2,
        CFG_LONG_BEEP_TICKS = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [DelayW-1:0]   lack_delay;
        logic [DelayW-1:0]   full_delay;
        logic [TimeoutW-1:0] clear_timeout;
        logic [DelayW-1:0]   long_beep_ticks;
    } wlab_cfg_t;

endpackage

FILE: rtl/water_level_alarm_buzzer.sv
// ----------------------------------------------------------------------------
// water_level_alarm_buzzer
// Tick-driven water lack / full alarm latch with buzzer pattern generator.
//
//   channel   dir   width  contents
//   s_axis    in    8      water_level [6:0], tick_active [7]
//   m_axis    out   8      buzzer_on [0], lack_alarm [1], full_alarm [2]
//   cfg       in    20     lack_delay, full_delay, clear_timeout, long_beep_ticks
//
// one tick per cycle while s_axis_tready is high; state and result register update in
// the cycle of the input transfer, the result shows on m_axis the next cycle.
// a waiting result stalls input only while m_axis_tready is low.
// synchronous active-low reset clears all state but out_data_reg, config returns to defaults.
// ----------------------------------------------------------------------------
module water_level_alarm_buzzer
    import wlab_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,   // water_level [6:0], tick_active [7]

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata,   // buzzer_on [0], lack_alarm [1], full_alarm [2]

    input  logic                cfg_wr_en,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgDataW-1:0] cfg_wr_data
);

    wlab_cfg_t cfg;

    wlab_cfg_regs u_cfg_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    logic [DelayW-1:0] empty_run_reg, empty_run_next;
    logic [DelayW-1:0] full_run_reg,  full_run_next;
    logic [BeepW-1:0]  beep_count_reg, beep_count_next;
    logic [ClearW-1:0] clear_run_reg, clear_run_next;
    logic [EventW-1:0] lack_events_reg, lack_events_next;
    logic              lack_reg, lack_next;
    logic              full_reg, full_next;
    logic              buzz_reg, buzz_next;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_data_reg, out_data_next;

    logic [LevelW-1:0] level;
    logic              active;
    logic              in_xfer;
    logic              lvl_empty, lvl_full, lvl_mid;
    logic [DelayW:0]   e_inc, f_inc;
    logic [BeepW-1:0]  b_inc;
    logic [ClearW-1:0] c_inc;

    assign level  = s_axis_tdata[LevelW-1:0];
    assign active = s_axis_tdata[LevelW];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign lvl_empty = (level == LEVEL_EMPTY);
    assign lvl_full  = (level == LEVEL_FULL);
    assign lvl_mid   = !lvl_empty && (level < LEVEL_FULL);

    always_comb begin
        empty_run_next   = empty_run_reg;
        full_run_next    = full_run_reg;
        beep_count_next  = beep_count_reg;
        clear_run_next   = clear_run_reg;
        lack_events_next = lack_events_reg;
        lack_next        = lack_reg;
        full_next        = full_reg;
        buzz_next        = buzz_reg;
        e_inc            = {1'b0, empty_run_reg} + 1'b1;
        f_inc            = {1'b0, full_run_reg} + 1'b1;
        b_inc            = '0;
        c_inc            = '0;

        if (in_xfer && active) begin
            // empty run
            if (lvl_empty && !lack_reg) begin
                if (e_inc > {1'b0, cfg.lack_delay}) begin
                    empty_run_next  = '0;
                    full_next       = 1'b0;
                    lack_next       = 1'b1;
                    beep_count_next = '0;
                    buzz_next       = 1'b0;
                    if (lack_events_reg < LACK_EVENTS_MAX) begin
                        lack_events_next = lack_events_reg + 1'b1;
                    end
                end else begin
                    empty_run_next = e_inc[DelayW-1:0];
                end
            end else begin
                empty_run_next = '0;
            end

            // full run, level full excludes a lack latch in this tick
            if (lvl_full && !full_reg) begin
                if (f_inc >= {1'b0, cfg.full_delay}) begin
                    full_run_next   = '0;
                    full_next       = 1'b1;
                    lack_next       = 1'b0;
                    beep_count_next = '0;
                    buzz_next       = 1'b0;
                end else begin
                    full_run_next = f_inc[DelayW-1:0];
                end
            end else begin
                full_run_next = '0;
            end

            b_inc = beep_count_next + 1'b1;

            // lack pattern
            if (lack_next) begin
                if (beep_count_next < LACK_WIN_END) begin
                    beep_count_next = b_inc;
                    if (lack_events_next == LACK_EVENTS_MAX) begin
                        if (b_inc < LACK_ON1_END) begin
                            buzz_next = 1'b1;
                        end else if (b_inc > LACK_ON1_END && b_inc < LACK_OFF_END) begin
                            buzz_next = 1'b0;
                        end else if (b_inc > LACK_OFF_END && b_inc < LACK_WIN_END) begin
                            buzz_next = 1'b1;
                        end
                    end
                end else begin
                    buzz_next = 1'b0;
                end
            end

            // long beep
            if (full_next) begin
                if (beep_count_next < cfg.long_beep_ticks) begin
                    beep_count_next = b_inc;
                    buzz_next       = 1'b1;
                end else begin
                    buzz_next = 1'b0;
                end
            end

            // clear timeout
            c_inc = clear_run_reg + 1'b1;
            if (lvl_mid && (lack_next || full_next)) begin
                if (c_inc > {1'b0, cfg.clear_timeout}) begin
                    clear_run_next = '0;
                    lack_next      = 1'b0;
                    full_next      = 1'b0;
                end else begin
                    clear_run_next = c_inc;
                end
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_xfer) begin
            out_valid_next = 1'b1;
            out_data_next  = {full_next, lack_next, buzz_next};
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_run_reg   <= '0;
            full_run_reg    <= '0;
            beep_count_reg  <= '0;
            clear_run_reg   <= '0;
            lack_events_reg <= '0;
            lack_reg        <= 1'b0;
            full_reg        <= 1'b0;
            buzz_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            empty_run_reg   <= empty_run_next;
            full_run_reg    <= full_run_next;
            beep_count_reg  <= beep_count_next;
            clear_run_reg   <= clear_run_next;
            lack_events_reg <= lack_events_next;
            lack_reg        <= lack_next;
            full_reg        <= full_next;
            buzz_reg        <= buzz_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OutDataW-3){1'b0}}, out_data_reg};

endmodule

FILE: rtl/wlab_cfg_regs.sv
// ----------------------------------------------------------------------------
// wlab_cfg_regs
// Configuration register file, write only, low register-width bits kept.
// ----------------------------------------------------------------------------
module wlab_cfg_regs
    import wlab_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgDataW-1:0] cfg_wr_data,
    output wlab_cfg_t           cfg
);

    wlab_cfg_t cfg_reg;
    wlab_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_LACK_DELAY:      cfg_next.lack_delay      = cfg_wr_data[DelayW-1:0];
                CFG_FULL_DELAY:      cfg_next.full_delay      = cfg_wr_data[DelayW-1:0];
                CFG_CLEAR_TIMEOUT:   cfg_next.clear_timeout   = cfg_wr_data[TimeoutW-1:0];
                CFG_LONG_BEEP_TICKS: cfg_next.long_beep_ticks = cfg_wr_data[DelayW-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lack_delay      <= LACK_DELAY_RST;
            cfg_reg.full_delay      <= FULL_DELAY_RST;
            cfg_reg.clear_timeout   <= CLEAR_TIMEOUT_RST;
            cfg_reg.long_beep_ticks <= LONG_BEEP_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for water_level_alarm_buzzer. Ticks are streamed in
// with random pacing on both sides. A scoreboard class mirrors the alarm
// latches, the run counters and the beep patterns, and compares every
// result transfer with its own prediction. Several register settings are
// used, including zero, truncated and full-scale values.
// ----------------------------------------------------------------------------
module testbench;
    import wlab_pkg::*;

    typedef struct packed {
        logic full_alarm;
        logic lack_alarm;
        logic buzzer_on;
    } alarm_out_t;

    typedef enum {RUN_EMPTY, RUN_FULL, RUN_MID, RUN_OVER, RUN_IDLE} run_kind_t;

    class alarm_scoreboard;
        logic [DelayW-1:0]   lack_delay;
        logic [DelayW-1:0]   full_delay;
        logic [TimeoutW-1:0] clear_limit;
        logic [DelayW-1:0]   beep_len;
        logic [DelayW-1:0]   empty_run;
        logic [DelayW-1:0]   full_run;
        logic [BeepW-1:0]    beep_count;
        logic [ClearW-1:0]   clear_run;
        logic [EventW-1:0]   lack_events;
        logic                lack_on;
        logic                full_on;
        logic                buzzer;
        alarm_out_t          pending_outputs[$];
        int                  errors;
        int                  ticks;
        int                  active_ticks;
        int                  lack_latches;
        int                  full_latches;
        int                  clears;

        function new();
            lack_delay   = LACK_DELAY_RST;
            full_delay   = FULL_DELAY_RST;
            clear_limit  = CLEAR_TIMEOUT_RST;
            beep_len     = LONG_BEEP_TICKS_RST;
            empty_run    = '0;
            full_run     = '0;
            beep_count   = '0;
            clear_run    = '0;
            lack_events  = '0;
            lack_on      = 1'b0;
            full_on      = 1'b0;
            buzzer       = 1'b0;
            errors       = 0;
            ticks        = 0;
            active_ticks = 0;
            lack_latches = 0;
            full_latches = 0;
            clears       = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] value);
            case (idx)
                CFG_LACK_DELAY:      lack_delay  = value[DelayW-1:0];
                CFG_FULL_DELAY:      full_delay  = value[DelayW-1:0];
                CFG_CLEAR_TIMEOUT:   clear_limit = value[TimeoutW-1:0];
                CFG_LONG_BEEP_TICKS: beep_len    = value[DelayW-1:0];
                default: ;
            endcase
        endfunction

        function void note_tick(logic [LevelW-1:0] level, logic active);
            int unsigned n;
            alarm_out_t  res;
            ticks++;
            if (active) begin
                active_ticks++;
                if (level == LEVEL_EMPTY && !lack_on) begin
                    n = empty_run + 1;
                    if (n > lack_delay) begin
                        empty_run  = '0;
                        full_on    = 1'b0;
                        lack_on    = 1'b1;
                        beep_count = '0;
                        buzzer     = 1'b0;
                        if (lack_events < LACK_EVENTS_MAX) lack_events++;
                        lack_latches++;
                    end else begin
                        empty_run = n[DelayW-1:0];
                    end
                end else begin
                    empty_run = '0;
                end

                if (level == LEVEL_FULL && !full_on) begin
                    n = full_run + 1;
                    if (n >= full_delay) begin
                        full_run   = '0;
                        full_on    = 1'b1;
                        lack_on    = 1'b0;
                        beep_count = '0;
                        buzzer     = 1'b0;
                        full_latches++;
                    end else begin
                        full_run = n[DelayW-1:0];
                    end
                end else begin
                    full_run = '0;
                end

                // on-off-on windows, edges of each window hold the level
                if (lack_on) begin
                    if (beep_count < LACK_WIN_END) begin
                        beep_count++;
                        if (lack_events == LACK_EVENTS_MAX) begin
                            if (beep_count < LACK_ON1_END)
                                buzzer = 1'b1;
                            else if (beep_count > LACK_ON1_END && beep_count < LACK_OFF_END)
                                buzzer = 1'b0;
                            else if (beep_count > LACK_OFF_END && beep_count < LACK_WIN_END)
                                buzzer = 1'b1;
                        end
                    end else begin
                        buzzer = 1'b0;
                    end
                end

                if (full_on) begin
                    if (beep_count < beep_len) begin
                        beep_count++;
                        buzzer = 1'b1;
                    end else begin
                        buzzer = 1'b0;
                    end
                end

                // clear run is only zeroed when it fires
                if (level > LEVEL_EMPTY && level < LEVEL_FULL && (lack_on || full_on)) begin
                    clear_run++;
                    if (clear_run > clear_limit) begin
                        clear_run = '0;
                        lack_on   = 1'b0;
                        full_on   = 1'b0;
                        clears++;
                    end
                end
            end
            res.buzzer_on  = buzzer;
            res.lack_alarm = lack_on;
            res.full_alarm = full_on;
            pending_outputs.push_back(res);
        endfunction

        function void check_output(logic [OutDataW-1:0] data);
            alarm_out_t got;
            alarm_out_t want;
            got = data[2:0];
            if (pending_outputs.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result transfer, buzzer %b lack %b full %b",
                             $time, got.buzzer_on, got.lack_alarm, got.full_alarm);
                return;
            end
            want = pending_outputs.pop_front();
            if (got.buzzer_on !== want.buzzer_on || got.lack_alarm !== want.lack_alarm ||
                    got.full_alarm !== want.full_alarm) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch, buzzer %b/%b lack %b/%b full %b/%b (exp/act)",
                             $time, want.buzzer_on, got.buzzer_on, want.lack_alarm,
                             got.lack_alarm, want.full_alarm, got.full_alarm);
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                cfg_wr_en;
    logic [CfgAddrW-1:0] cfg_addr;
    logic [CfgDataW-1:0] cfg_wr_data;

    alarm_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int settings_used = 0;

    water_level_alarm_buzzer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_output(m_axis_tdata);
        end
    end

    initial begin
        #3000000;
        $display("timeout with %0d results outstanding", sb.pending_outputs.size());
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_tick(input logic [LevelW-1:0] level, input logic active);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {active, level};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_tick(level, active);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending_outputs.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic set_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        sb.write_reg(idx, value);
        @(negedge aclk);
    endtask

    task automatic program_regs(input logic [CfgDataW-1:0] lack, input logic [CfgDataW-1:0] full,
                                input logic [CfgDataW-1:0] clr, input logic [CfgDataW-1:0] beep);
        set_reg(CFG_LACK_DELAY, lack);
        set_reg(CFG_FULL_DELAY, full);
        set_reg(CFG_CLEAR_TIMEOUT, clr);
        set_reg(CFG_LONG_BEEP_TICKS, beep);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        settings_used++;
    endtask

    task automatic play_run(input run_kind_t kind, input int len);
        logic [LevelW-1:0] lvl;
        logic              act;
        for (int i = 0; i < len; i++) begin
            act = 1'b1;
            case (kind)
                RUN_EMPTY: lvl = LEVEL_EMPTY;
                RUN_FULL:  lvl = LEVEL_FULL;
                RUN_MID:   lvl = LevelW'($urandom_range(1, 99));
                RUN_OVER:  lvl = LevelW'($urandom_range(101, 127));
                default: begin
                    lvl = LevelW'($urandom_range(0, 127));
                    act = 1'b0;
                end
            endcase
            // dropped link ticks sprinkled inside runs
            if ($urandom_range(99) < 4) begin
                lvl = LevelW'($urandom_range(0, 127));
                act = 1'b0;
            end
            send_tick(lvl, act);
        end
    endtask

    function automatic run_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 30) return RUN_EMPTY;
        if (r < 60) return RUN_FULL;
        if (r < 85) return RUN_MID;
        if (r < 92) return RUN_OVER;
        return RUN_IDLE;
    endfunction

    task automatic play_phase(input int n_active, input int max_len);
        int start;
        start = sb.active_ticks;
        while (sb.active_ticks - start < n_active)
            play_run(pick_kind(), $urandom_range(1, max_len));
        wait_drained();
    endtask

    task automatic random_small_phase(input int n_active);
        program_regs(CfgDataW'($urandom_range(1, 30)), CfgDataW'($urandom_range(1, 30)),
                     CfgDataW'($urandom_range(1, 60)), CfgDataW'($urandom_range(1, 80)));
        play_phase(n_active, 16);
    endtask

    initial begin
        sb            = new();
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = CFG_LACK_DELAY;
        cfg_wr_data   = '0;
        send_idle_pct = 25;
        recv_idle_pct = 72;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // default settings, level extremes and out-of-range levels
        send_tick(LEVEL_EMPTY, 1'b1);
        send_tick(LEVEL_FULL, 1'b1);
        send_tick(7'd127, 1'b1);
        send_tick(7'd101, 1'b1);
        send_tick(7'd1, 1'b1);
        send_tick(7'd99, 1'b1);
        send_tick(7'd50, 1'b0);
        send_tick(LEVEL_EMPTY, 1'b0);
        wait_drained();

        // register values of one: lack, full, clear, then the second lack event
        program_regs(20'd1, 20'd1, 20'd1, 20'd1);
        play_run(RUN_EMPTY, 2);
        play_run(RUN_FULL, 2);
        play_run(RUN_MID, 2);
        play_run(RUN_EMPTY, 3);
        send_tick(7'd127, 1'b1);
        send_tick(LEVEL_EMPTY, 1'b0);
        wait_drained();

        // zero delays, upper data bits dropped by the narrow registers
        program_regs(20'hFF000, 20'd0, 20'd0, 20'hAB000);
        send_tick(LEVEL_EMPTY, 1'b1);
        send_tick(LEVEL_FULL, 1'b1);
        send_tick(7'd42, 1'b1);
        send_tick(LEVEL_FULL, 1'b1);
        wait_drained();

        program_regs(20'd1, 20'd1, 20'd1, 20'd1);
        play_phase(40, 4);
        program_regs(20'd4095, 20'd4095, 20'd1048575, 20'd4095);
        play_phase(30, 20);
        random_small_phase(20);

        send_idle_pct = 72;
        recv_idle_pct = 25;
        random_small_phase(20);
        // fresh lack latch held through the whole on-off-on window
        program_regs(20'd2, 20'd3, 20'd50, CfgDataW'($urandom_range(100, 300)));
        play_run(RUN_FULL, 4);
        repeat (1510) send_tick(LEVEL_EMPTY, 1'b1);
        play_phase(20, 20);
        random_small_phase(20);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_regs(20'd5, 20'd5, 20'd100, 20'd30);
        play_phase(20, 20);
        random_small_phase(20);
        wait_drained();

        $display("ran %0d ticks (%0d active) under %0d register settings",
                 sb.ticks, sb.active_ticks, settings_used);
        $display("saw %0d lack latches, %0d full latches and %0d timeout clears",
                 sb.lack_latches, sb.full_latches, sb.clears);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches in total", sb.errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
